// ----- src/tlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpm_pkg
// shared types and constants of the trie longest prefix match unit
// ----------------------------------------------------------------------------
package tlpm_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int MAX_KEY_LEN = 255;
   localparam int POS_W       = $clog2(MAX_KEY_LEN + 1);
   localparam int BASE_W      = 32;
   localparam int CHECK_W     = 16;
   localparam int VALUE_W     = 31;
   localparam int LEN_W       = 8;
   localparam int LEN_MAX     = 255;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_KEY   = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [15:0]              entry_index;
      logic signed [BASE_W-1:0] entry_base;
      logic [CHECK_W-1:0]       entry_check;
      logic [7:0]               key_byte;
      logic                     key_last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [LEN_W-1:0]   match_len;
      logic [VALUE_W-1:0] match_value;
      logic               key_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOAD_ROOT,
      ST_GOT_ROOT,
      ST_DECIDE,
      ST_GOT_NODE,
      ST_GOT_TRANS,
      ST_FINISH,
      ST_GOT_FINAL,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      ADDR_ROOT,
      ADDR_NODE,
      ADDR_TRANS
   } addr_sel_type;

   typedef struct packed {
      logic         capture;
      logic         mem_write;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         load_root;
      logic         mark_overflow;
      logic         advance;
      logic         kill;
      logic         term_test;
      logic         follow;
      logic         respond;
   } cmd_type;

   typedef struct packed {
      logic key_started;
      logic key_last;
      logic walk_dead;
      logic pos_full;
      logic node_ok;
      logic trans_ok;
   } status_type;

endpackage

// ----- src/tlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpm_ctrl
// sequencer for table writes and the per-byte trie walk
// ----------------------------------------------------------------------------
module tlpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_func,
   input  tlpm_pkg::status_type status,
   output tlpm_pkg::cmd_type    cmd,
   output logic                busy
);
   import tlpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.addr_sel = ADDR_ROOT;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               if (req_func == FUNC_WRITE) begin
                  state_in = ST_WRITE;
               end else if (status.key_started) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_LOAD_ROOT;
               end
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_LOAD_ROOT: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_ROOT;
            state_in     = ST_GOT_ROOT;
         end
         ST_GOT_ROOT: begin
            cmd.load_root = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.pos_full) begin
               cmd.mark_overflow = 1'b1;
               state_in          = ST_FINISH;
            end else if (status.walk_dead) begin
               cmd.advance = 1'b1;
               state_in    = ST_FINISH;
            end else if (!status.node_ok) begin
               cmd.kill    = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_NODE;
               state_in     = ST_GOT_NODE;
            end
         end
         ST_GOT_NODE: begin
            cmd.term_test = 1'b1;
            if (status.trans_ok) begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_TRANS;
               state_in     = ST_GOT_TRANS;
            end else begin
               cmd.kill    = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_GOT_TRANS: begin
            cmd.follow  = 1'b1;
            cmd.advance = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.key_last) begin
               state_in = ST_IDLE;
            end else if (!status.walk_dead && status.node_ok) begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_NODE;
               state_in     = ST_GOT_FINAL;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_GOT_FINAL: begin
            cmd.term_test = 1'b1;
            state_in      = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/tlpm_datapath.sv -----
// ----------------------------------------------------------------------------
// tlpm_datapath
// trie table memory, walk registers and result register
// ----------------------------------------------------------------------------
module tlpm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tlpm_pkg::req_type    req_data,
   input  tlpm_pkg::cmd_type    cmd,
   output tlpm_pkg::status_type status,
   output logic                 rsp_valid,
   output tlpm_pkg::rsp_type    rsp_data
);
   import tlpm_pkg::*;

   localparam int WORD_W = BASE_W + CHECK_W;

   logic [WORD_W-1:0] mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_ff;

   req_type             req_ff;
   logic [BASE_W-1:0]   node_base_ff,   node_base_in;
   logic                key_started_ff, key_started_in;
   logic                walk_dead_ff,   walk_dead_in;
   logic [POS_W-1:0]    byte_pos_ff,    byte_pos_in;
   logic [POS_W-1:0]    best_len_ff,    best_len_in;
   logic [VALUE_W-1:0]  best_value_ff,  best_value_in;
   logic                best_found_ff,  best_found_in;
   logic                overflow_ff,    overflow_in;
   logic                rsp_valid_ff,   rsp_valid_in;
   rsp_type             rsp_data_ff,    rsp_data_in;

   logic [BASE_W:0]     trans_sum;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_ok;
   logic [BASE_W-1:0]   rd_base;
   logic [CHECK_W-1:0]  rd_check;
   logic                check_match;

   assign rd_base     = rd_ff[WORD_W-1:CHECK_W];
   assign rd_check    = rd_ff[CHECK_W-1:0];
   assign check_match = (BASE_W'(rd_check) == node_base_ff);
   assign trans_sum   = {1'b0, node_base_ff} + (BASE_W+1)'(req_ff.key_byte)
                        + (BASE_W+1)'(1);
   assign wr_ok       = (32'(req_ff.entry_index) < 32'(TABLE_DEPTH));

   assign status.key_started = key_started_ff;
   assign status.key_last    = req_ff.key_last;
   assign status.walk_dead   = walk_dead_ff;
   assign status.pos_full    = (32'(byte_pos_ff) >= 32'(MAX_KEY_LEN));
   assign status.node_ok     = !node_base_ff[BASE_W-1]
                               && (node_base_ff < BASE_W'(TABLE_DEPTH));
   assign status.trans_ok    = status.node_ok
                               && (trans_sum < (BASE_W+1)'(TABLE_DEPTH));

   always_comb begin
      case (cmd.addr_sel)
         ADDR_ROOT:  rd_addr = '0;
         ADDR_NODE:  rd_addr = node_base_ff[ADDR_W-1:0];
         ADDR_TRANS: rd_addr = trans_sum[ADDR_W-1:0];
         default:    rd_addr = '0;
      endcase
   end

   // table memory, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_ok) begin
         mem[ADDR_W'(req_ff.entry_index)] <= {req_ff.entry_base, req_ff.entry_check};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      node_base_in   = node_base_ff;
      key_started_in = key_started_ff;
      walk_dead_in   = walk_dead_ff;
      byte_pos_in    = byte_pos_ff;
      best_len_in    = best_len_ff;
      best_value_in  = best_value_ff;
      best_found_in  = best_found_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;

      if (cmd.load_root) begin
         node_base_in   = rd_base;
         key_started_in = 1'b1;
      end
      if (cmd.mark_overflow) begin
         overflow_in = 1'b1;
      end
      if (cmd.advance) begin
         byte_pos_in = byte_pos_ff + POS_W'(1);
      end
      if (cmd.kill) begin
         walk_dead_in = 1'b1;
      end
      // terminal child: check points at this node and base is negative
      if (cmd.term_test && check_match && rd_base[BASE_W-1]) begin
         best_found_in = 1'b1;
         best_len_in   = byte_pos_ff;
         best_value_in = ~rd_base[VALUE_W-1:0];
      end
      if (cmd.follow) begin
         if (check_match) begin
            node_base_in = rd_base;
         end else begin
            walk_dead_in = 1'b1;
         end
      end
      if (cmd.respond) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.found        = best_found_ff;
         rsp_data_in.match_len    = !best_found_ff ? '0
                                    : (32'(best_len_ff) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                    : LEN_W'(best_len_ff);
         rsp_data_in.match_value  = best_found_ff ? best_value_ff : '0;
         rsp_data_in.key_overflow = overflow_ff;
         node_base_in   = '0;
         key_started_in = 1'b0;
         walk_dead_in   = 1'b0;
         byte_pos_in    = '0;
         best_len_in    = '0;
         best_value_in  = '0;
         best_found_in  = 1'b0;
         overflow_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_base_ff   <= '0;
         key_started_ff <= 1'b0;
         walk_dead_ff   <= 1'b0;
         byte_pos_ff    <= '0;
         best_len_ff    <= '0;
         best_value_ff  <= '0;
         best_found_ff  <= 1'b0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         node_base_ff   <= node_base_in;
         key_started_ff <= key_started_in;
         walk_dead_ff   <= walk_dead_in;
         byte_pos_ff    <= byte_pos_in;
         best_len_ff    <= best_len_in;
         best_value_ff  <= best_value_in;
         best_found_ff  <= best_found_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/trie_longest_prefix_match_unit.sv -----
// ----------------------------------------------------------------------------
// trie_longest_prefix_match_unit
// longest prefix match over a double-array trie held in on-chip memory
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; it either writes one
// trie slot (base and check words) or presents one key byte. a key byte on a
// live walk reads the node slot and then the transition slot, each a registered
// read of the single-port table memory; a dead or overflowed walk, or a node
// outside the table, skips both reads, and a transition slot past the end of
// the table skips the second. a key's first byte first fetches the root from
// slot 0, and its last byte may add the final terminal test before the result.
// the result for a key appears on rsp_data for exactly one cycle with rsp_valid
// high, in the cycle where busy has already dropped; the receiver cannot stall,
// so it must take the result in that cycle. the table has no reset: slots read
// before being written give undefined results
module trie_longest_prefix_match_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tlpm_pkg::req_type req_data,
   output logic              rsp_valid,
   output tlpm_pkg::rsp_type rsp_data
);
   import tlpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: one request at a time
   tlpm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // memory, walk state and result register
   tlpm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result only follows a cycle of work on a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // the result is shown once the sequencer is back in idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // an accepted request always occupies the block in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

   // a match length never exceeds the key length limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.match_len) <= 32'(MAX_KEY_LEN)))
      else $error("match length beyond key limit");

endmodule

// ----- sim/tb_trie_longest_prefix_match_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trie_longest_prefix_match_unit
// self-checking bench: loads random double-array tries, walks keys through
// them and checks each longest-match result against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_trie_longest_prefix_match_unit;
   import tlpm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 30;    // quiet cycles once nothing is awaited
   localparam int LOW_TOP     = 511;   // low window: stray writes land up to here
   localparam int HIGH_BOT    = 65279; // high window: node bases 65279..65535

   // predictor of the match unit plus the queue of results it still awaits
   class match_scoreboard;
      bit [BASE_W-1:0]  slot_base [TABLE_DEPTH];
      bit [CHECK_W-1:0] slot_check [TABLE_DEPTH];
      bit               slot_written [TABLE_DEPTH];
      longint           walk_node;
      bit               key_started;
      bit               walk_dead;
      int unsigned      byte_pos;
      int unsigned      best_len;
      bit [VALUE_W-1:0] best_value;
      bit               best_found;
      bit               overflow_seen;
      rsp_type          awaited_matches [$];
      int               errors;

      function new();
         errors = 0;
         clear_key();
      endfunction

      function void clear_key();
         walk_node     = 0;
         key_started   = 1'b0;
         walk_dead     = 1'b0;
         byte_pos      = 0;
         best_len      = 0;
         best_value    = '0;
         best_found    = 1'b0;
         overflow_seen = 1'b0;
      endfunction

      function bit slot_ok(longint idx);
         return idx >= 0 && idx < TABLE_DEPTH;
      endfunction

      // node the next key byte starts from
      function longint current_node();
         return key_started ? walk_node : longint'($signed(slot_base[0]));
      endfunction

      function void note_terminal();
         if (slot_ok(walk_node) && longint'(slot_check[walk_node]) == walk_node &&
               slot_base[walk_node][BASE_W-1]) begin
            best_found = 1'b1;
            best_len   = byte_pos;
            best_value = ~slot_base[walk_node][VALUE_W-1:0];
         end
      endfunction

      function int pending();
         return awaited_matches.size();
      endfunction

      function void note_request(req_type r);
         longint  p;
         rsp_type m;
         if (r.func == FUNC_WRITE) begin
            slot_base[r.entry_index]    = r.entry_base;
            slot_check[r.entry_index]   = r.entry_check;
            slot_written[r.entry_index] = 1'b1;
            return;
         end
         if (!key_started) begin
            walk_node   = current_node();
            key_started = 1'b1;
         end
         if (byte_pos >= MAX_KEY_LEN) begin
            overflow_seen = 1'b1;
         end else begin
            if (!walk_dead) begin
               note_terminal();
               p = walk_node + longint'(r.key_byte) + 1;
               if (slot_ok(walk_node) && slot_ok(p) && longint'(slot_check[p]) == walk_node)
                  walk_node = longint'($signed(slot_base[p]));
               else
                  walk_dead = 1'b1;
            end
            byte_pos++;
         end
         if (r.key_last != 1'b1)
            return;
         if (!walk_dead)
            note_terminal();
         m.found        = best_found;
         m.match_len    = !best_found ? '0
                          : LEN_W'((best_len > LEN_MAX) ? LEN_MAX : best_len);
         m.match_value  = best_found ? best_value : '0;
         m.key_overflow = overflow_seen;
         awaited_matches = {awaited_matches, m};
         clear_key();
      endfunction

      function void report_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_matches.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0h", $time, got);
            errors++;
            return;
         end
         want = awaited_matches.pop_front();
         report_field("found", want.found, got.found);
         report_field("match_len", want.match_len, got.match_len);
         report_field("match_value", want.match_value, got.match_value);
         report_field("key_overflow", want.key_overflow, got.key_overflow);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   match_scoreboard sb = new();
   int cycle_count = 0;
   int gap_pct = 0;   // chance of a sender idle burst after each request

   trie_longest_prefix_match_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // results last one cycle and cannot be held off, so sample every edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_data);
   end

   // present one request and hold it until the edge that takes it;
   // start is only assigned when it changes, so it never toggles within a step
   task automatic send_request(input req_type r);
      if (start !== 1'b1)
         start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic pause(input int cycles);
      if (start !== 1'b0)
         start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_pause();
      if ($urandom_range(99) < gap_pct)
         pause($urandom_range(12, 1));
   endtask

   // hold off the sender until every awaited result has come back
   task automatic drain();
      if (start !== 1'b0)
         start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // unused fields carry random bits so that the block is seen to ignore them
   function automatic req_type noise_request();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // every base written is negative, past the end of the table, or a slot
   // already loaded, so a walk never lands on a node that was never written
   function automatic logic [BASE_W-1:0] safe_base();
      int idx;
      idx = 0;
      case ($urandom_range(3))
         0: return {1'b1, 31'($urandom)};
         1: idx = $urandom_range(255);
         2: idx = $urandom_range(65535, HIGH_BOT);
         default: return $urandom_range(32'h7fff_ffff, TABLE_DEPTH);
      endcase
      if (sb.slot_written[idx])
         return BASE_W'(idx);
      return {1'b1, 31'($urandom)};
   endfunction

   task automatic write_slot(input int index, input logic [BASE_W-1:0] base,
                             input logic [CHECK_W-1:0] check);
      req_type r;
      r             = noise_request();
      r.func        = FUNC_WRITE;
      r.entry_index = 16'(index);
      r.entry_base  = base;
      r.entry_check = check;
      send_request(r);
      maybe_pause();
   endtask

   task automatic send_key(input logic [7:0] kb, input logic last);
      req_type r;
      r          = noise_request();
      r.func     = FUNC_KEY;
      r.key_byte = kb;
      r.key_last = last;
      send_request(r);
      maybe_pause();
   endtask

   // mostly follow a live transition of the node the walk stands on,
   // otherwise a random byte that will usually kill the walk
   function automatic logic [7:0] choose_key_byte();
      longint     node;
      longint     p;
      logic [7:0] live [$];
      node = sb.current_node();
      if (!sb.walk_dead && sb.slot_ok(node) && $urandom_range(99) < 88) begin
         for (int b = 0; b < 256; b++) begin
            p = node + b + 1;
            if (sb.slot_ok(p) && longint'(sb.slot_check[p]) == node)
               live = {live, b[7:0]};
         end
      end
      if (live.size() == 0)
         return $urandom_range(255);
      return live[$urandom_range(live.size() - 1)];
   endfunction

   // a byte whose transition slot was never loaded gets that slot written first
   task automatic send_walk_key(input logic last);
      logic [7:0] kb;
      longint     node;
      longint     p;
      kb   = choose_key_byte();
      node = sb.current_node();
      p    = node + longint'(kb) + 1;
      if (!sb.walk_dead && sb.byte_pos < MAX_KEY_LEN && sb.slot_ok(node) &&
            sb.slot_ok(p) && !sb.slot_written[p])
         write_slot(int'(p), safe_base(), 16'($urandom));
      send_key(kb, last);
   endtask

   // a small random trie: a handful of nodes, some terminal, with children
   // pointing back into the node set so that walks can run deep and loop
   task automatic build_trie();
      int     node [8];
      int     p;
      logic [BASE_W-1:0] child;
      for (int i = 0; i < 8; i++)
         node[i] = (i == 7) ? $urandom_range(65535, HIGH_BOT) : $urandom_range(255);
      foreach (node[i]) begin
         if ($urandom_range(1))
            write_slot(node[i], {1'b1, 31'($urandom)}, node[i]);
         else
            write_slot(node[i], safe_base(), $urandom);
      end
      write_slot(0, node[0], $urandom);
      foreach (node[i]) begin
         repeat ($urandom_range(5, 2)) begin
            p = node[i] + $urandom_range(255) + 1;
            child = ($urandom_range(3) != 0) ? node[$urandom_range(7)] : safe_base();
            if (p < TABLE_DEPTH)
               write_slot(p, child, node[i]);
         end
      end
   endtask

   // random part: mostly keys walked along the trie, some stray writes
   // mid-key, and optionally one key just past the length limit
   task automatic run_phase(input int n_items, input bit with_long_key,
                            input bit fresh_trie);
      int left;
      int done;
      bit long_sent;
      left      = 0;
      done      = 0;
      long_sent = 1'b0;
      if (fresh_trie)
         build_trie();
      while (done < n_items || left != 0) begin
         if (left == 0) begin
            if (with_long_key && !long_sent && done > n_items / 3) begin
               left      = MAX_KEY_LEN + 1;
               long_sent = 1'b1;
            end else if ($urandom_range(3) != 0) begin
               left = $urandom_range(4, 1);
            end else begin
               left = $urandom_range(12, 5);
            end
         end
         if ($urandom_range(99) < 8) begin
            if ($urandom_range(1))
               write_slot($urandom_range(LOW_TOP), safe_base(), $urandom);
            else
               write_slot($urandom_range(65535, HIGH_BOT), safe_base(), $urandom);
         end else begin
            send_walk_key(left == 1);
            left--;
         end
         done++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;

      // directed trie: root node 16 is itself terminal (empty prefix, value 0)
      write_slot(0, 16, 16'hffff);
      write_slot(16, 32'hffff_ffff, 16);
      write_slot(17, 40, 16);                     // byte 00 -> node 40
      write_slot(22, 32'h7fff_ffff, 16'h0015);    // slot owned by another parent
      write_slot(272, 32'h8000_0000, 16);         // byte ff -> negative node
      write_slot(40, 32'h8000_0000, 40);          // terminal, largest value
      write_slot(106, 65500, 40);                 // byte 41 -> node near the top
      write_slot(65500, 32'hffff_fffb, 65500);    // terminal, value 4
      write_slot(65531, 32'h7fff_ffff, 65500);    // byte 1e -> node past the table
      write_slot(65535, 32'h7fff_ffff, 16'hffff);

      // walk to a node beyond the table, then the next byte dies
      send_key(8'h00, 1'b0);
      send_key(8'h41, 1'b0);
      send_key(8'h1e, 1'b0);
      send_key(8'h77, 1'b1);
      // single byte into a negative node: only the empty prefix matches
      send_key(8'hff, 1'b1);
      // transition index runs off the top of the table
      send_key(8'h00, 1'b0);
      send_key(8'h41, 1'b0);
      send_key(8'hff, 1'b1);
      // failed first transition
      send_key(8'h05, 1'b1);
      // slot written in the middle of a key, used by its next byte
      send_key(8'h00, 1'b0);
      write_slot(107, 16, 40);
      send_key(8'h42, 1'b0);
      send_key(8'h00, 1'b1);
      drain();

      // random phases; the first and last load a fresh trie while the bench is quiet
      gap_pct = 25;
      run_phase(40, 1'b0, 1'b1);
      drain();
      gap_pct = 50;
      run_phase(24, 1'b1, 1'b0);
      drain();
      // last part runs flat out
      gap_pct = 0;
      run_phase(40, 1'b0, 1'b1);
      drain();

      if (sb.errors == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
